// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define B2B_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

`define B2B_IMPLY(lbl, ante, cons) \
    `B2B_ASSERT(lbl, (ante) |-> (cons))

`endif

// ===== design/b2b_pkg.sv =====
// ----------------------------------------------------------------------------
// BLAKE2b package
// Payload types, controller/datapath interface and hash constants.
// ----------------------------------------------------------------------------
package b2b_pkg;

    localparam int C_ROUNDS = 12;

    localparam logic [63:0] C_IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] C_PARAM_BASE = 64'h0000_0000_0101_0000;

    localparam logic [3:0] C_SIGMA [10][16] = '{
        '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
        '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
        '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
        '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
        '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
        '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
        '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
        '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
        '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
        '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
    };

    localparam logic       C_FUNC_MSG = 1'b0;
    localparam logic       C_FUNC_KEY = 1'b1;

    localparam logic [1:0] C_REG_DIGEST_LEN = 2'd0;
    localparam logic [1:0] C_REG_KEY_LEN    = 2'd1;

    typedef struct packed {
        logic        func;
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  digest_index;
        logic        last_word;
    } t_out;

    typedef struct packed {
        logic accept;
        logic start;
        logic pad;
        logic merge;
        logic fin;
        logic add128;
        logic cinit;
        logic crun;
        logic cend;
        logic out_adv;
    } t_cmd;

    typedef struct packed {
        logic is_key;
        logic need_pad;
        logic merge_comp;
        logic last;
        logic fin_comp;
        logic comp_done;
        logic out_last;
        logic final_blk;
    } t_sts;

    function automatic logic [3:0] f_sigma(input logic [3:0] rnd, input logic [3:0] pos);
        logic [3:0] r;
        r = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
        return C_SIGMA[r][pos];
    endfunction

endpackage

// ===== design/b2b_ctrl.sv =====
// ----------------------------------------------------------------------------
// BLAKE2b controller
// Sequences item intake, block compression and digest output.
// ----------------------------------------------------------------------------
module b2b_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  b2b_pkg::t_sts i_sts,
    output b2b_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);
    import b2b_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PAD   = 8'b0000_0010,
        S_MERGE = 8'b0000_0100,
        S_FIN   = 8'b0000_1000,
        S_CINIT = 8'b0001_0000,
        S_CRUN  = 8'b0010_0000,
        S_CEND  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_run, n_run;
    logic   r_ret_fin, n_ret_fin;

    always_comb begin
        n_state   = r_state;
        n_run     = r_run;
        n_ret_fin = r_ret_fin;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.start  = !r_run;
                    n_run        = 1'b1;
                    n_state      = S_PAD;
                end
            end
            S_PAD: begin
                o_cmd.pad = i_sts.need_pad;
                n_state   = S_MERGE;
            end
            S_MERGE: begin
                if (i_sts.merge_comp) begin
                    o_cmd.add128 = 1'b1;
                    n_ret_fin    = 1'b0;
                    n_state      = S_CINIT;
                end else begin
                    o_cmd.merge = 1'b1;
                    n_state     = (!i_sts.is_key && i_sts.last) ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (i_sts.fin_comp) begin
                    o_cmd.add128 = 1'b1;
                    n_ret_fin    = 1'b1;
                end else begin
                    o_cmd.fin = 1'b1;
                end
                n_state = S_CINIT;
            end
            S_CINIT: begin
                o_cmd.cinit = 1'b1;
                n_state     = S_CRUN;
            end
            S_CRUN: begin
                o_cmd.crun = 1'b1;
                if (i_sts.comp_done) begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                o_cmd.cend = 1'b1;
                if (i_sts.final_blk) begin
                    n_state = S_OUT;
                end else begin
                    n_state = r_ret_fin ? S_FIN : S_MERGE;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    o_cmd.out_adv = 1'b1;
                    if (i_sts.out_last) begin
                        n_run   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_run     <= 1'b0;
            r_ret_fin <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_run     <= n_run;
            r_ret_fin <= n_ret_fin;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

// ===== design/b2b_dp.sv =====
// ----------------------------------------------------------------------------
// BLAKE2b datapath
// Byte packing into the block memory, byte counter, chain value and a
// four-phase mixing unit working on a row-rotated work vector.
// ----------------------------------------------------------------------------
module b2b_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  b2b_pkg::t_cmd i_cmd,
    output b2b_pkg::t_sts o_sts,
    input  b2b_pkg::t_in  i_item,
    input  logic [6:0]    i_dlen,
    input  logic [6:0]    i_klen,
    output b2b_pkg::t_out o_out
);
    import b2b_pkg::*;

    t_in          r_item;
    logic [63:0]  r_h [8];
    logic [127:0] r_count;
    logic [63:0]  r_mem [16];
    logic [4:0]   r_wcnt;
    logic [63:0]  r_stage;
    logic [2:0]   r_scnt;
    logic         r_full;
    logic         r_in_msg;
    logic         r_final;
    logic [63:0]  r_v [4][4];
    logic [3:0]   r_rnd;
    logic [2:0]   r_step;
    logic [1:0]   r_ph;
    logic [63:0]  r_mrd;
    logic         r_mzero;
    logic [2:0]   r_oidx;

    logic [3:0]   nb;
    logic [7:0]   fill;
    logic         is_key;
    logic [63:0]  dm;
    logic [127:0] merged;
    logic [3:0]   total;
    logic         need_write;
    logic         key_ok;
    logic         do_merge;
    logic         we;
    logic [63:0]  wdata;
    logic [3:0]   raddr;
    logic [63:0]  gm;
    logic [63:0]  sum_a;
    logic [63:0]  sum_c;
    logic [63:0]  t [4][4];
    logic [1:0]   kr [4];
    logic [7:0]   nsum;
    logic [3:0]   nwords;
    logic [6:0]   rem;
    logic [63:0]  h_sel;
    logic [63:0]  masked;

    assign nb     = (r_item.valid_bytes > 4'd8) ? 4'd8 : r_item.valid_bytes;
    assign fill   = {r_wcnt, 3'b000} + {5'b00000, r_scnt};
    assign is_key = (r_item.func == C_FUNC_KEY);

    always_comb begin
        logic [7:0] pos;
        for (int j = 0; j < 8; j++) begin
            pos = fill + 8'(j);
            if ((4'(j) < nb) && (!is_key || (pos < {1'b0, i_klen}))) begin
                dm[8*j +: 8] = r_item.data_word[8*j +: 8];
            end else begin
                dm[8*j +: 8] = 8'h00;
            end
        end
    end

    assign merged     = {64'd0, r_stage} | ({64'd0, dm} << {r_scnt, 3'b000});
    assign total      = {1'b0, r_scnt} + nb;
    assign need_write = total[3];
    assign key_ok     = (i_klen != 7'd0) && !r_in_msg && !r_full;
    assign do_merge   = i_cmd.merge && (!is_key || key_ok);

    always_comb begin
        we    = 1'b0;
        wdata = r_stage;
        if (do_merge && need_write) begin
            we    = 1'b1;
            wdata = merged[63:0];
        end
        if (i_cmd.pad && (i_klen != 7'd0) && (r_scnt != 3'd0)) begin
            we = 1'b1;
        end
        if (i_cmd.fin && !r_full && (r_scnt != 3'd0)) begin
            we = 1'b1;
        end
    end

    always_comb begin
        if (i_cmd.cinit) begin
            raddr = f_sigma(4'd0, 4'd0);
        end else if (r_ph == 2'd3) begin
            if (r_step == 3'd7) begin
                raddr = f_sigma(4'(r_rnd + 4'd1), 4'd0);
            end else begin
                raddr = f_sigma(r_rnd, {3'(r_step + 3'd1), 1'b0});
            end
        end else begin
            raddr = f_sigma(r_rnd, {r_step, 1'b1});
        end
    end

    assign gm    = r_mzero ? 64'd0 : r_mrd;
    assign sum_a = r_v[0][0] + r_v[1][0] + gm;
    assign sum_c = r_v[2][0] + r_v[3][0];

    always_comb begin
        logic [63:0] x;
        t = r_v;
        x = 64'd0;
        case (r_ph)
            2'd0: begin
                x       = r_v[3][0] ^ sum_a;
                t[0][0] = sum_a;
                t[3][0] = {x[31:0], x[63:32]};
            end
            2'd1: begin
                x       = r_v[1][0] ^ sum_c;
                t[2][0] = sum_c;
                t[1][0] = {x[23:0], x[63:24]};
            end
            2'd2: begin
                x       = r_v[3][0] ^ sum_a;
                t[0][0] = sum_a;
                t[3][0] = {x[15:0], x[63:16]};
            end
            2'd3: begin
                x       = r_v[1][0] ^ sum_c;
                t[2][0] = sum_c;
                t[1][0] = {x[62:0], x[63]};
            end
            default: begin
                x = 64'd0;
            end
        endcase
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            if (r_step == 3'd3) begin
                kr[r] = 2'(2'd1 + 2'(r));
            end else if (r_step == 3'd7) begin
                kr[r] = 2'(2'd1 - 2'(r));
            end else begin
                kr[r] = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mrd   <= r_mem[raddr];
        r_mzero <= ({1'b0, raddr} >= r_wcnt);
        if (we) begin
            r_mem[r_wcnt[3:0]] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        if (i_cmd.start) begin
            for (int i = 1; i < 8; i++) begin
                r_h[i] <= C_IV[i];
            end
            r_h[0] <= C_IV[0] ^ C_PARAM_BASE ^ {49'd0, i_klen, 8'd0} ^ {57'd0, i_dlen};
            r_count <= 128'd0;
        end
        if (i_cmd.add128) begin
            r_count <= r_count + 128'd128;
        end
        if (i_cmd.fin) begin
            r_count <= r_count + (r_full ? 128'd128 : {120'd0, fill});
        end
        if (i_cmd.cinit) begin
            for (int j = 0; j < 4; j++) begin
                r_v[0][j] <= r_h[j];
                r_v[1][j] <= r_h[4 + j];
                r_v[2][j] <= C_IV[j];
            end
            r_v[3][0] <= C_IV[4] ^ r_count[63:0];
            r_v[3][1] <= C_IV[5] ^ r_count[127:64];
            r_v[3][2] <= C_IV[6] ^ {64{r_final}};
            r_v[3][3] <= C_IV[7];
        end
        if (i_cmd.crun) begin
            for (int r = 0; r < 4; r++) begin
                for (int j = 0; j < 4; j++) begin
                    if (r_ph == 2'd3) begin
                        r_v[r][j] <= t[r][2'(2'(j) + kr[r])];
                    end else begin
                        r_v[r][j] <= t[r][j];
                    end
                end
            end
        end
        if (i_cmd.cend) begin
            for (int j = 0; j < 4; j++) begin
                r_h[j]     <= r_h[j] ^ r_v[0][j] ^ r_v[2][j];
                r_h[4 + j] <= r_h[4 + j] ^ r_v[1][j] ^ r_v[3][j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt   <= 5'd0;
            r_stage  <= 64'd0;
            r_scnt   <= 3'd0;
            r_full   <= 1'b0;
            r_in_msg <= 1'b0;
            r_final  <= 1'b0;
            r_rnd    <= 4'd0;
            r_step   <= 3'd0;
            r_ph     <= 2'd0;
            r_oidx   <= 3'd0;
        end else begin
            if (i_cmd.start) begin
                r_wcnt   <= 5'd0;
                r_stage  <= 64'd0;
                r_scnt   <= 3'd0;
                r_full   <= 1'b0;
                r_in_msg <= 1'b0;
            end
            if (i_cmd.pad) begin
                r_in_msg <= 1'b1;
                if (i_klen != 7'd0) begin
                    if (r_scnt != 3'd0) begin
                        r_wcnt <= 5'(r_wcnt + 5'd1);
                    end
                    r_stage <= 64'd0;
                    r_scnt  <= 3'd0;
                    r_full  <= 1'b1;
                end
            end
            if (do_merge) begin
                if (need_write) begin
                    r_wcnt <= 5'(r_wcnt + 5'd1);
                    if (r_wcnt == 5'd15) begin
                        r_full <= 1'b1;
                    end
                    if (is_key && (r_wcnt == 5'd15)) begin
                        r_stage <= 64'd0;
                        r_scnt  <= 3'd0;
                    end else begin
                        r_stage <= merged[127:64];
                        r_scnt  <= total[2:0];
                    end
                end else begin
                    r_stage <= merged[63:0];
                    r_scnt  <= total[2:0];
                end
            end
            if (i_cmd.add128) begin
                r_final <= 1'b0;
            end
            if (i_cmd.fin) begin
                r_final <= 1'b1;
                if (!r_full && (r_scnt != 3'd0)) begin
                    r_wcnt  <= 5'(r_wcnt + 5'd1);
                    r_stage <= 64'd0;
                    r_scnt  <= 3'd0;
                end
            end
            if (i_cmd.cinit) begin
                r_rnd  <= 4'd0;
                r_step <= 3'd0;
                r_ph   <= 2'd0;
            end
            if (i_cmd.crun) begin
                r_ph <= 2'(r_ph + 2'd1);
                if (r_ph == 2'd3) begin
                    r_step <= 3'(r_step + 3'd1);
                    if (r_step == 3'd7) begin
                        r_rnd <= 4'(r_rnd + 4'd1);
                    end
                end
            end
            if (i_cmd.cend) begin
                r_wcnt <= 5'd0;
                r_full <= 1'b0;
                r_oidx <= 3'd0;
            end
            if (i_cmd.out_adv) begin
                r_oidx <= 3'(r_oidx + 3'd1);
            end
        end
    end

    assign nsum   = {1'b0, i_dlen} + 8'd7;
    assign nwords = nsum[6:3];
    assign rem    = i_dlen - {1'b0, r_oidx, 3'b000};
    assign h_sel  = r_h[r_oidx];

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            masked[8*j +: 8] = (7'(j) < rem) ? h_sel[8*j +: 8] : 8'h00;
        end
    end

    assign o_out.digest_word  = masked;
    assign o_out.digest_index = r_oidx;
    assign o_out.last_word    = ({1'b0, r_oidx} == 4'(nwords - 4'd1));

    assign o_sts.is_key     = is_key;
    assign o_sts.need_pad   = !is_key && !r_in_msg;
    assign o_sts.merge_comp = !is_key && need_write && r_full;
    assign o_sts.last       = r_item.last;
    assign o_sts.fin_comp   = r_full && (r_scnt != 3'd0);
    assign o_sts.comp_done  = (r_rnd == 4'(C_ROUNDS - 1)) && (r_step == 3'd7) && (r_ph == 2'd3);
    assign o_sts.out_last   = o_out.last_word;
    assign o_sts.final_blk  = r_final;

endmodule

// ===== design/blake2b_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// BLAKE2b stream hasher, top level
// Keyed or unkeyed BLAKE2b over a stream of little-endian 64-bit words.
//
//   Channel   Direction  Handshake             Content
//   in        input      i_in_valid/o_in_stall  key or message word
//   out       output     o_out_valid/i_out_stall digest word
//   cfg       input      i_cfg_valid/o_cfg_ready digest and key length
//
// A word that does not close a block passes through the idle, pad and merge states.
// To compress a block, the single mixing unit does each of the 96 mixing steps of
// the 12 rounds in four phases.
// After the last word the digest goes out one word per cycle while the output is not stalled, up to eight.
// Synchronous reset restores the default lengths; a stall on the output
// holds the current digest word and blocks new input.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blake2b_stream_hasher_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  b2b_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output b2b_pkg::t_out o_out_data,
    input  logic          i_out_stall,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [6:0]    i_cfg_data
);
    import b2b_pkg::*;

    logic [6:0] r_dlen;
    logic [6:0] r_klen;
    logic [6:0] dlen_eff;
    logic [6:0] klen_eff;
    t_cmd       cmd;
    t_sts       sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlen <= 7'd32;
            r_klen <= 7'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                C_REG_DIGEST_LEN: begin
                    r_dlen <= i_cfg_data;
                end
                C_REG_KEY_LEN: begin
                    r_klen <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign dlen_eff = (r_dlen == 7'd0) ? 7'd1 : ((r_dlen > 7'd64) ? 7'd64 : r_dlen);
    assign klen_eff = (r_klen > 7'd64) ? 7'd64 : r_klen;

    b2b_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    b2b_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_item  (i_in_data),
        .i_dlen  (dlen_eff),
        .i_klen  (klen_eff),
        .o_out   (o_out_data)
    );

    `B2B_IMPLY(a_out_blocks_in, o_out_valid, o_in_stall)
    `B2B_IMPLY(a_first_index, $rose(o_out_valid), o_out_data.digest_index == 3'd0)
    `B2B_ASSERT(a_last_ends, (o_out_valid && !i_out_stall && o_out_data.last_word) |=> !o_out_valid)

endmodule

// ===== dv/blake2b_stream_hasher_top_test.sv =====
// ----------------------------------------------------------------------------
// BLAKE2b stream hasher testbench
// Feeds keyed and unkeyed runs of key and message words under several length
// settings, with random input gaps and output stalls. A built-in BLAKE2b
// calculation predicts every digest word, and the monitor checks each output
// transfer field by field.
// ----------------------------------------------------------------------------
module blake2b_stream_hasher_top_test;
    import b2b_pkg::*;

    localparam int MIX_POS [8][4] = '{
        '{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
        '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    t_in        i_in_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out       o_out_data;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [6:0] i_cfg_data = '0;

    blake2b_stream_hasher_top dut (.*);

    always #2 i_clk = ~i_clk;

    logic [63:0] chain [8];
    logic [63:0] block_words [16];
    logic [63:0] mix_v [16];
    logic [63:0] byte_cnt_lo, byte_cnt_hi;
    int          fill;
    bit          run_open, msg_started;
    logic [6:0]  digest_len_reg = 7'd32;
    logic [6:0]  key_len_reg = 7'd0;

    t_in  pending_words [$];
    t_out digest_q [$];
    int   errors = 0;
    int   items_queued = 0;
    bit   sender_gaps = 1'b1;
    bit   receiver_hold = 1'b0;

    function automatic int digest_bytes();
        if (digest_len_reg < 1) return 1;
        if (digest_len_reg > 64) return 64;
        return digest_len_reg;
    endfunction

    function automatic int key_bytes();
        return (key_len_reg > 64) ? 64 : key_len_reg;
    endfunction

    function automatic void start_run();
        for (int i = 0; i < 8; i++) chain[i] = C_IV[i];
        chain[0] ^= 64'h0101_0000 ^ (64'(key_bytes()) << 8) ^ 64'(digest_bytes());
        byte_cnt_lo = '0;
        byte_cnt_hi = '0;
        for (int i = 0; i < 16; i++) block_words[i] = '0;
        fill = 0;
        msg_started = 1'b0;
    endfunction

    function automatic logic [63:0] rotr(logic [63:0] x, int c);
        return (x >> c) | (x << (64 - c));
    endfunction

    function automatic void mix_step(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
        mix_v[a] = mix_v[a] + mix_v[b] + x;
        mix_v[d] = rotr(mix_v[d] ^ mix_v[a], 32);
        mix_v[c] = mix_v[c] + mix_v[d];
        mix_v[b] = rotr(mix_v[b] ^ mix_v[c], 24);
        mix_v[a] = mix_v[a] + mix_v[b] + y;
        mix_v[d] = rotr(mix_v[d] ^ mix_v[a], 16);
        mix_v[c] = mix_v[c] + mix_v[d];
        mix_v[b] = rotr(mix_v[b] ^ mix_v[c], 63);
    endfunction

    function automatic void compress_block(bit fin);
        for (int i = 0; i < 8; i++) begin
            mix_v[i] = chain[i];
            mix_v[i + 8] = C_IV[i];
        end
        mix_v[12] ^= byte_cnt_lo;
        mix_v[13] ^= byte_cnt_hi;
        if (fin) mix_v[14] = ~mix_v[14];
        for (int r = 0; r < 12; r++) begin
            for (int g = 0; g < 8; g++) begin
                mix_step(MIX_POS[g][0], MIX_POS[g][1], MIX_POS[g][2], MIX_POS[g][3],
                         block_words[C_SIGMA[r % 10][2 * g]],
                         block_words[C_SIGMA[r % 10][2 * g + 1]]);
            end
        end
        for (int i = 0; i < 8; i++) chain[i] ^= mix_v[i] ^ mix_v[i + 8];
    endfunction

    function automatic void add_bytes(logic [63:0] inc);
        byte_cnt_lo += inc;
        if (byte_cnt_lo < inc) byte_cnt_hi += 1;
    endfunction

    function automatic void put_byte(int pos, logic [7:0] b);
        block_words[(pos >> 3) & 15][(pos & 7) * 8 +: 8] = b;
    endfunction

    function automatic void pad_block();
        while (fill < 128) begin
            put_byte(fill, 8'h00);
            fill++;
        end
    endfunction

    function automatic void hash_word(t_in w);
        int   nb;
        int   klen;
        int   dlen;
        int   n;
        t_out r;
        nb = (w.valid_bytes > 8) ? 8 : w.valid_bytes;
        if (!run_open) begin
            start_run();
            run_open = 1'b1;
        end
        if (w.func == C_FUNC_KEY) begin
            klen = key_bytes();
            if (klen == 0 || msg_started) return;
            for (int i = 0; i < nb && fill < 128; i++) begin
                put_byte(fill, (fill < klen) ? w.data_word[8 * i +: 8] : 8'h00);
                fill++;
            end
            return;
        end
        if (!msg_started) begin
            msg_started = 1'b1;
            if (key_bytes() != 0) pad_block();
        end
        for (int i = 0; i < nb; i++) begin
            if (fill >= 128) begin
                add_bytes(64'd128);
                compress_block(1'b0);
                fill = 0;
            end
            put_byte(fill, w.data_word[8 * i +: 8]);
            fill++;
        end
        if (!w.last) return;
        add_bytes(64'(fill));
        pad_block();
        compress_block(1'b1);
        dlen = digest_bytes();
        n = (dlen + 7) / 8;
        for (int i = 0; i < n; i++) begin
            r.digest_word = chain[i];
            if (dlen - 8 * i < 8) r.digest_word &= (64'd1 << (8 * (dlen - 8 * i))) - 1;
            r.digest_index = 3'(i);
            r.last_word = (i + 1 == n);
            digest_q.push_back(r);
        end
        start_run();
        run_open = 1'b0;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) hash_word(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_in_data <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap = sender_gaps ? pick_gap() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    int hold_cycles = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (receiver_hold && hold_cycles == 0) begin
            hold_cycles = 900;
            receiver_hold = 1'b0;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_left = sender_gaps ? pick_gap() : 0;
            i_out_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, exp_val, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected digest transfer", o_out_data.digest_word, '0);
            end else begin
                e = digest_q.pop_front();
                if (o_out_data.digest_word !== e.digest_word)
                    report_mismatch("digest_word", o_out_data.digest_word, e.digest_word);
                if (o_out_data.digest_index !== e.digest_index)
                    report_mismatch("digest_index", 64'(o_out_data.digest_index),
                                    64'(e.digest_index));
                if (o_out_data.last_word !== e.last_word)
                    report_mismatch("last_word", 64'(o_out_data.last_word), 64'(e.last_word));
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [6:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == C_REG_DIGEST_LEN) digest_len_reg = value;
        else key_len_reg = value;
        if (!run_open) start_run();
    endtask

    task automatic set_lengths(logic [6:0] dlen, logic [6:0] klen);
        write_reg(C_REG_DIGEST_LEN, dlen);
        write_reg(C_REG_KEY_LEN, klen);
    endtask

    function automatic t_in make_word(logic func, int vb, logic last);
        t_in w;
        w.func = func;
        w.data_word = {$urandom, $urandom};
        w.valid_bytes = 4'(vb);
        w.last = last;
        return w;
    endfunction

    // A run of nkey key words and nmsg message words (late_key adds a key word after
    // the first); the final message word, or with nmsg 0 an empty one, is flagged last.
    task automatic queue_run(int nkey, int nmsg, bit late_key, bit odd_sizes);
        int vb;
        for (int i = 0; i < nkey; i++) begin
            vb = odd_sizes ? $urandom_range(0, 15) : 8;
            pending_words.push_back(make_word(C_FUNC_KEY, vb, 1'($urandom_range(0, 1))));
        end
        for (int i = 0; i < nmsg; i++) begin
            vb = odd_sizes ? $urandom_range(0, 15) : 8;
            if (i == nmsg - 1) vb = $urandom_range(0, 15);
            pending_words.push_back(make_word(C_FUNC_MSG, vb, i == nmsg - 1));
            if (late_key && i == 0)
                pending_words.push_back(make_word(C_FUNC_KEY, 8, 1'b1));
        end
        if (nmsg == 0) pending_words.push_back(make_word(C_FUNC_MSG, 0, 1'b1));
        items_queued += nkey + ((nmsg == 0) ? 1 : nmsg) + ((late_key && nmsg > 0) ? 1 : 0);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || digest_q.size() != 0);
        repeat (800) @(posedge i_clk);
    endtask

    function automatic void ref_init();
        digest_len_reg = 7'd32;
        key_len_reg = 7'd0;
        start_run();
        run_open = 1'b0;
    endfunction

    initial begin
        logic [6:0] dl, kl;
        ref_init();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_lengths(7'd32, 7'd0);
        queue_run(0, 0, 0, 0);
        queue_run(2, 3, 0, 0);
        queue_run(0, 16, 0, 0);
        drain();

        set_lengths(7'd64, 7'd64);
        queue_run(8, 0, 0, 0);
        queue_run(17, 2, 0, 0);
        queue_run(3, 2, 1, 1);
        drain();

        set_lengths(7'd1, 7'd1);
        queue_run(1, 17, 0, 0);
        drain();

        set_lengths(7'd127, 7'd127);
        queue_run(2, 1, 0, 1);
        drain();
        set_lengths(7'd0, 7'd0);
        queue_run(0, 2, 0, 1);
        drain();

        for (int phase = 0; items_queued < 100; phase++) begin
            case ($urandom_range(0, 3))
                0: dl = 7'd64;
                1: dl = 7'd1;
                default: dl = 7'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: kl = 7'd0;
                1: kl = 7'd64;
                default: kl = 7'($urandom);
            endcase
            set_lengths(dl, kl);
            sender_gaps = (phase % 3 != 2);
            if (phase == 0) receiver_hold = 1'b1;
            for (int k = 0; k < 3; k++) begin
                queue_run((kl != 0) ? $urandom_range(0, 9) : $urandom_range(0, 2),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                                      : $urandom_range(0, 6),
                          $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
            end
            drain();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
